@@ hw/rtl/irlt_pkg.sv @@
// shared types and codes for the interval range lookup table
// no dependencies; imported by irlt_scan and interval_range_lookup_table
package irlt_pkg;

   localparam int ADDR_W   = 64;
   localparam int HANDLE_W = 32;
   localparam int STATUS_W = 3;

   // request opcodes
   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_FIND   = 1'b1;

   // response status codes
   localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
   localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd1;
   localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
   localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd3;
   localparam logic [STATUS_W-1:0] ST_NOTFOUND  = 3'd4;

   // one stored interval
   typedef struct packed {
      logic [ADDR_W-1:0]   start;
      logic [ADDR_W-1:0]   size;
      logic [HANDLE_W-1:0] handle;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   // control from the sequencer to the scan unit
   typedef struct packed {
      logic clear;    // start of a new item
      logic data_vld; // ram read data holds an entry to evaluate
      logic find;     // evaluate as a find, else as a duplicate check
   } scan_ctl_type;

endpackage

@@ hw/rtl/irlt_ram.sv @@
// generic simple dual-port ram, one write port and one registered read port
// no dependencies
module irlt_ram #(
   parameter int WIDTH = 160,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/irlt_scan.sv @@
// scan unit: evaluates one stored entry per cycle against the current item
// depends on irlt_pkg
module irlt_scan
   import irlt_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  scan_ctl_type        ctl,
   input  logic [ADDR_W-1:0]   key,
   input  logic [ADDR_W-1:0]   size,
   input  entry_type           rd_data,
   output logic                hit,
   output logic [HANDLE_W-1:0] best_handle
);

   logic                hit_ff, hit_in;
   logic [ADDR_W-1:0]   best_start_ff, best_start_in;
   logic [ADDR_W-1:0]   best_size_ff, best_size_in;
   logic [HANDLE_W-1:0] best_handle_ff, best_handle_in;
   logic                covers;
   logic                ahead;
   logic                dup;

   // end is start+size at 65 bits, so test the offset instead
   assign covers = (key >= rd_data.start) && ((key - rd_data.start) <= rd_data.size);
   assign ahead  = !hit_ff || (rd_data.start < best_start_ff) ||
                   ((rd_data.start == best_start_ff) && (rd_data.size < best_size_ff));
   assign dup    = (rd_data.start == key) && (rd_data.size == size);

   always_comb begin
      hit_in         = hit_ff;
      best_start_in  = best_start_ff;
      best_size_in   = best_size_ff;
      best_handle_in = best_handle_ff;
      if (ctl.clear) begin
         hit_in = 1'b0;
      end else if (ctl.data_vld) begin
         if (ctl.find) begin
            if (covers && ahead) begin
               hit_in         = 1'b1;
               best_start_in  = rd_data.start;
               best_size_in   = rd_data.size;
               best_handle_in = rd_data.handle;
            end
         end else if (dup) begin
            hit_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff <= 1'b0;
      end else begin
         hit_ff <= hit_in;
      end
      best_start_ff  <= best_start_in;
      best_size_ff   <= best_size_in;
      best_handle_ff <= best_handle_in;
   end

   assign hit         = hit_ff;
   assign best_handle = best_handle_ff;

endmodule

@@ hw/rtl/interval_range_lookup_table.sv @@
// interval range lookup table, top level
// each request scans all held entries, then its result is registered for the response
// throughput: one item at a time, one stored entry read per cycle from the entry ram
// so a new request beat is taken only once the previous result has left S_FIN
// reset: synchronous, clears the entry count and the control state; ram contents untouched
// depends on irlt_pkg, irlt_ram, irlt_scan
module interval_range_lookup_table
   import irlt_pkg::*;
#(
   parameter int CAPACITY = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_opcode,
   input  logic [ADDR_W-1:0]   req_start_addr,
   input  logic [ADDR_W-1:0]   req_span_size,
   input  logic [HANDLE_W-1:0] req_handle_in,
   input  logic [ADDR_W-1:0]   req_query_addr,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [HANDLE_W-1:0] rsp_handle_out
);

   localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;  // ram index width
   localparam int CW = $clog2(CAPACITY + 1);                   // count width

   // sequencer states
   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_SCAN = 2'd1;
   localparam logic [1:0] S_FIN  = 2'd2;

   logic [1:0]          state_ff, state_in;
   logic                op_ff, op_in;
   logic [ADDR_W-1:0]   key_ff, key_in;      // insert start or find address
   logic [ADDR_W-1:0]   size_ff, size_in;
   logic [HANDLE_W-1:0] handle_ff, handle_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [CW-1:0]       rd_idx_ff, rd_idx_in;
   logic                rd_vld_ff, rd_vld_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [HANDLE_W-1:0] rsp_handle_ff, rsp_handle_in;

   logic                req_beat;
   logic                issue;      // read of the next entry this cycle
   logic                fin_go;     // result leaves for the response register
   logic                room;
   logic                wr_en;
   logic [STATUS_W-1:0] fin_status;
   entry_type           wr_entry;
   entry_type           rd_entry;
   logic [ENTRY_W-1:0]  rd_bits;
   scan_ctl_type        scan_ctl;
   logic                scan_hit;
   logic [HANDLE_W-1:0] scan_handle;

   assign req_ready = (state_ff == S_IDLE);
   assign req_beat  = req_valid && req_ready;
   assign issue     = (state_ff == S_SCAN) && (rd_idx_ff < count_ff);
   assign fin_go    = (state_ff == S_FIN) && (!rsp_valid_ff || rsp_ready);
   assign room      = (count_ff < CW'(CAPACITY));

   // duplicates win over a full table; a miss reports zero handle
   always_comb begin
      if (op_ff == OP_FIND) begin
         fin_status = scan_hit ? ST_FOUND : ST_NOTFOUND;
      end else if (scan_hit) begin
         fin_status = ST_DUPLICATE;
      end else if (room) begin
         fin_status = ST_INSERTED;
      end else begin
         fin_status = ST_FULL;
      end
   end

   // new entry goes to the slot just past the filled ones, after the full scan,
   // so a write never overlaps a read of the same item
   assign wr_en           = fin_go && (op_ff == OP_INSERT) && !scan_hit && room;
   assign wr_entry.start  = key_ff;
   assign wr_entry.size   = size_ff;
   assign wr_entry.handle = handle_ff;

   irlt_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[IW-1:0]),
      .wr_data (wr_entry),
      .rd_en   (issue),
      .rd_addr (rd_idx_ff[IW-1:0]),
      .rd_data (rd_bits)
   );

   assign rd_entry = rd_bits;

   assign scan_ctl.clear    = req_beat;
   assign scan_ctl.data_vld = rd_vld_ff;
   assign scan_ctl.find     = (op_ff == OP_FIND);

   irlt_scan u_scan (
      .clock       (clock),
      .reset       (reset),
      .ctl         (scan_ctl),
      .key         (key_ff),
      .size        (size_ff),
      .rd_data     (rd_entry),
      .hit         (scan_hit),
      .best_handle (scan_handle)
   );

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      key_in        = key_ff;
      size_in       = size_ff;
      handle_in     = handle_ff;
      count_in      = count_ff;
      rd_idx_in     = rd_idx_ff;
      rd_vld_in     = issue;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_handle_in = rsp_handle_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_beat) begin
               op_in     = req_opcode;
               key_in    = (req_opcode == OP_FIND) ? req_query_addr : req_start_addr;
               size_in   = req_span_size;
               handle_in = req_handle_in;
               rd_idx_in = '0;
               state_in  = S_SCAN;
            end
         end
         S_SCAN: begin
            if (issue) begin
               rd_idx_in = rd_idx_ff + CW'(1);
            end else if (!rd_vld_ff) begin
               // last entry evaluated
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (fin_go) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = fin_status;
               rsp_handle_in = (fin_status == ST_FOUND) ? scan_handle : '0;
               if (wr_en) begin
                  count_in = count_ff + CW'(1);
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rd_idx_ff    <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rd_idx_ff    <= rd_idx_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff         <= op_in;
      key_ff        <= key_in;
      size_ff       <= size_in;
      handle_ff     <= handle_in;
      rsp_status_ff <= rsp_status_in;
      rsp_handle_ff <= rsp_handle_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_handle_out = rsp_handle_ff;

`ifndef SYNTHESIS
   // the table never holds more than its capacity
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("entry count beyond capacity");

   // reads only touch filled slots
   a_read_filled: assert property (@(posedge clock) disable iff (reset)
      issue |-> (rd_idx_ff < count_ff))
      else $error("read of an unfilled slot");

   // a new entry is written only at the end of a non-duplicate insert
   a_write_insert: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> ((state_ff == S_FIN) && (op_ff == OP_INSERT) && !rd_vld_ff))
      else $error("entry write outside insert completion");

   // a successful insert grows the table by exactly one
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> (count_ff == $past(count_ff) + CW'(1)))
      else $error("entry count did not advance on insert");
`endif

endmodule
